@@ src/first_fit_heap_allocator_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the heap allocator checkers.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH

// check on every clock edge outside reset
`define FFHA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("allocator assertion failed");

// check on every clock edge, reset included
`define FFHA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("allocator reset assertion failed");

`endif

@@ src/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// Heap allocator package
// Types, codes and default sizes shared by the allocator modules.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 32;
  localparam int OFFSET_BITS_DEF  = 24;

  localparam int HB_W    = 25;
  localparam int FIELD_W = 24;
  localparam logic [HB_W-1:0] HB_RESET = 25'd16777216;

  localparam int ROUND_ADD   = 7;
  localparam int SPLIT_SLACK = 16;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } ffha_op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_BADFREE = 2'd2,
    ST_NOINIT  = 2'd3
  } ffha_status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_PREP1, S_PREP2, S_PREP3,
    S_ARD, S_AEV, S_ASPL, S_NOFF, S_NSZ,
    S_SRD, S_SWR, S_WNEW, S_WCUR,
    S_FRD, S_FEV, S_MRD, S_MEV, S_MADD, S_MWR,
    S_PRD, S_PEV, S_PADD, S_PWR, S_DONE
  } ffha_state_t;

  typedef struct packed {
    ffha_op_t             cmd;
    logic [FIELD_W-1:0]   req_size;
    logic [FIELD_W-1:0]   free_addr;
  } ffha_cmd_t;

  typedef struct packed {
    ffha_status_t         status;
    logic [FIELD_W-1:0]   grant_addr;
    logic [FIELD_W-1:0]   grant_size;
  } ffha_res_t;

endpackage

@@ src/ffha_if.sv @@
// ----------------------------------------------------------------------------
// Heap allocator channels
// Request, result and configuration channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface ffha_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic [ffha_pkg::FIELD_W-1:0] req_size;
  logic [ffha_pkg::FIELD_W-1:0] free_addr;
  modport source (output valid, cmd, req_size, free_addr, input ready);
  modport sink   (input valid, cmd, req_size, free_addr, output ready);
endinterface

interface ffha_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [ffha_pkg::FIELD_W-1:0] grant_addr;
  logic [ffha_pkg::FIELD_W-1:0] grant_size;
  modport source (output valid, status, grant_addr, grant_size, input ready);
  modport sink   (input valid, status, grant_addr, grant_size, output ready);
endinterface

interface ffha_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [ffha_pkg::HB_W-1:0] heap_bytes;
  modport source (output valid, heap_bytes, input ready);
  modport sink   (input valid, heap_bytes, output ready);
endinterface

@@ src/ffha_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/ffha_alu.sv @@
// ----------------------------------------------------------------------------
// Shared adder
// Add or subtract with borrow out, reused by every size and offset step of the sequencer.
// ----------------------------------------------------------------------------
module ffha_alu #(
  parameter int W = 26
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] y,
  output logic         borrow
);

  logic carry;

  assign {carry, y} = sub ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});
  assign borrow = sub & carry;

endmodule

@@ src/ffha_seq.sv @@
// ----------------------------------------------------------------------------
// Allocator sequencer
// Writes the first table entry on init and walks the block table for allocate and free using one shared adder.
// ----------------------------------------------------------------------------
module ffha_seq #(
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int OFFSET_BITS  = ffha_pkg::OFFSET_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ffha_pkg::HB_W-1:0] heap_bytes,
  input  logic                      start,
  input  ffha_pkg::ffha_cmd_t       cmd_in,
  output logic                      idle,
  output logic                      res_valid,
  input  logic                      res_take,
  output ffha_pkg::ffha_res_t       res
);

  localparam int OB = OFFSET_BITS;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int EW = 2 * OB + 1;
  localparam int AW = (OB > ffha_pkg::HB_W ? OB : ffha_pkg::HB_W) + 1;
  localparam int FW = ffha_pkg::FIELD_W;

  localparam logic [AW-1:0] H_A       = AW'(HEADER_BYTES);
  localparam logic [AW-1:0] LIMIT     = AW'(1) << OB;
  localparam logic [AW-1:0] ROUND_A   = AW'(ffha_pkg::ROUND_ADD);
  localparam logic [AW-1:0] SPLIT_MIN = AW'(ffha_pkg::SPLIT_SLACK + 1);

  function automatic logic [AW-1:0] ext_o(input logic [OB-1:0] x);
    return {{(AW-OB){1'b0}}, x};
  endfunction

  function automatic logic [AW-1:0] ext_f(input logic [FW-1:0] x);
    return {{(AW-FW){1'b0}}, x};
  endfunction

  ffha_pkg::ffha_state_t  state, state_next, ret;
  ffha_pkg::ffha_status_t status;
  logic          heap_ready, shift_up, split;
  logic [CW-1:0] count, i, k;
  logic [FW-1:0] req, faddr, gaddr, gsize;
  logic [AW-1:0] r, rh, thr1, acc;
  logic [OB-1:0] foff, fsize, noff, nsz;
  logic [AW-1:0] foff_ext, fsize_ext;

  logic [AW-1:0] alu_a, alu_b, alu_y;
  logic          alu_sub, alu_borrow;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  logic [OB-1:0] rd_off, rd_size;
  logic          rd_free;
  logic [AW-1:0] hb_ext, hb;
  logic [CW:0]   i_inc;
  logic [CW-1:0] i_dec, k_dec, k_inc;
  logic          i_lt, i1_lt, shift_more, fit, hit, room;

  assign rd_off  = rdata[OB-1:0];
  assign rd_size = rdata[2*OB-1:OB];
  assign rd_free = rdata[2*OB];

  assign foff_ext  = ext_o(foff);
  assign fsize_ext = ext_o(fsize);

  assign hb_ext = {{(AW-ffha_pkg::HB_W){1'b0}}, heap_bytes};
  assign hb     = (hb_ext > LIMIT) ? LIMIT : hb_ext;

  assign i_inc = {1'b0, i} + 1'b1;
  assign i_dec = i - 1'b1;
  assign k_dec = k - 1'b1;
  assign k_inc = k + 1'b1;
  assign i_lt  = i < count;
  assign i1_lt = i_inc < {1'b0, count};
  assign shift_more = shift_up ? ({1'b0, k} > i_inc)
                               : (({1'b0, k} + 1'b1) < {1'b0, count});
  assign fit   = rd_free && !alu_borrow;
  assign hit   = (alu_y == '0);
  assign room  = count < CW'(MAX_BLOCKS);

  ffha_alu #(.W(AW)) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .y      (alu_y),
    .borrow (alu_borrow)
  );

  ffha_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ffha_pkg::S_IDLE: begin
        if (start) begin
          case (cmd_in.cmd)
            ffha_pkg::OP_INIT:  state_next = ffha_pkg::S_INIT;
            ffha_pkg::OP_ALLOC: state_next = heap_ready ? ffha_pkg::S_PREP1
                                                        : ffha_pkg::S_DONE;
            ffha_pkg::OP_FREE: begin
              state_next = (heap_ready && cmd_in.free_addr != '0) ? ffha_pkg::S_FRD
                                                                  : ffha_pkg::S_DONE;
            end
            default: state_next = ffha_pkg::S_DONE;
          endcase
        end
      end
      ffha_pkg::S_INIT:  state_next = ffha_pkg::S_DONE;
      ffha_pkg::S_PREP1: state_next = ffha_pkg::S_PREP2;
      ffha_pkg::S_PREP2: state_next = ffha_pkg::S_PREP3;
      ffha_pkg::S_PREP3: state_next = ffha_pkg::S_ARD;
      ffha_pkg::S_ARD:   state_next = i_lt ? ffha_pkg::S_AEV : ffha_pkg::S_DONE;
      ffha_pkg::S_AEV:   state_next = fit ? ffha_pkg::S_ASPL : ffha_pkg::S_ARD;
      ffha_pkg::S_ASPL: begin
        state_next = (!alu_borrow && room) ? ffha_pkg::S_NOFF : ffha_pkg::S_WCUR;
      end
      ffha_pkg::S_NOFF:  state_next = ffha_pkg::S_NSZ;
      ffha_pkg::S_NSZ:   state_next = ffha_pkg::S_SRD;
      ffha_pkg::S_SRD:   state_next = shift_more ? ffha_pkg::S_SWR : ret;
      ffha_pkg::S_SWR:   state_next = ffha_pkg::S_SRD;
      ffha_pkg::S_WNEW:  state_next = ffha_pkg::S_WCUR;
      ffha_pkg::S_WCUR:  state_next = ffha_pkg::S_DONE;
      ffha_pkg::S_FRD:   state_next = i_lt ? ffha_pkg::S_FEV : ffha_pkg::S_DONE;
      ffha_pkg::S_FEV:   state_next = hit ? ffha_pkg::S_MRD : ffha_pkg::S_FRD;
      ffha_pkg::S_MRD:   state_next = i1_lt ? ffha_pkg::S_MEV : ffha_pkg::S_MWR;
      ffha_pkg::S_MEV:   state_next = rd_free ? ffha_pkg::S_MADD : ffha_pkg::S_MWR;
      ffha_pkg::S_MADD:  state_next = ffha_pkg::S_SRD;
      ffha_pkg::S_MWR: begin
        state_next = (i != '0) ? ffha_pkg::S_PRD : ffha_pkg::S_DONE;
      end
      ffha_pkg::S_PRD:   state_next = ffha_pkg::S_PEV;
      ffha_pkg::S_PEV:   state_next = rd_free ? ffha_pkg::S_PADD : ffha_pkg::S_DONE;
      ffha_pkg::S_PADD:  state_next = ffha_pkg::S_PWR;
      ffha_pkg::S_PWR:   state_next = ffha_pkg::S_SRD;
      ffha_pkg::S_DONE:  state_next = res_take ? ffha_pkg::S_IDLE : ffha_pkg::S_DONE;
      default:           state_next = ffha_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    raddr   = '0;
    case (state)
      ffha_pkg::S_INIT: begin
        alu_a   = hb;
        alu_b   = H_A;
        alu_sub = 1'b1;
        we      = 1'b1;
        wdata   = {1'b1, (alu_borrow ? {OB{1'b0}} : alu_y[OB-1:0]), H_A[OB-1:0]};
      end
      ffha_pkg::S_PREP1: begin
        alu_a = ext_f(req);
        alu_b = ROUND_A;
      end
      ffha_pkg::S_PREP2: begin
        alu_a = r;
        alu_b = H_A;
      end
      ffha_pkg::S_PREP3: begin
        alu_a = rh;
        alu_b = SPLIT_MIN;
      end
      ffha_pkg::S_ARD, ffha_pkg::S_FRD: raddr = i[IW-1:0];
      ffha_pkg::S_AEV: begin
        alu_a   = ext_o(rd_size);
        alu_b   = r;
        alu_sub = 1'b1;
      end
      ffha_pkg::S_ASPL: begin
        alu_a   = ext_o(fsize);
        alu_b   = thr1;
        alu_sub = 1'b1;
      end
      ffha_pkg::S_NOFF: begin
        alu_a = ext_o(foff);
        alu_b = rh;
      end
      ffha_pkg::S_NSZ: begin
        alu_a   = ext_o(fsize);
        alu_b   = rh;
        alu_sub = 1'b1;
      end
      ffha_pkg::S_SRD: raddr = shift_up ? k_dec[IW-1:0] : k_inc[IW-1:0];
      ffha_pkg::S_SWR: begin
        we    = 1'b1;
        waddr = k[IW-1:0];
        wdata = rdata;
      end
      ffha_pkg::S_WNEW: begin
        we    = 1'b1;
        waddr = i_inc[IW-1:0];
        wdata = {1'b1, nsz, noff};
      end
      ffha_pkg::S_WCUR: begin
        we    = 1'b1;
        waddr = i[IW-1:0];
        wdata = {1'b0, (split ? r[OB-1:0] : fsize), foff};
      end
      ffha_pkg::S_FEV: begin
        alu_a   = ext_o(rd_off);
        alu_b   = ext_f(faddr);
        alu_sub = 1'b1;
      end
      ffha_pkg::S_MRD: raddr = i_inc[IW-1:0];
      ffha_pkg::S_MEV: begin
        alu_a = acc;
        alu_b = ext_o(rd_size);
      end
      ffha_pkg::S_MADD, ffha_pkg::S_PEV: begin
        alu_a = acc;
        alu_b = H_A;
      end
      ffha_pkg::S_MWR: begin
        we    = 1'b1;
        waddr = i[IW-1:0];
        wdata = {1'b1, acc[OB-1:0], foff};
      end
      ffha_pkg::S_PRD: raddr = i_dec[IW-1:0];
      ffha_pkg::S_PADD: begin
        alu_a = acc;
        alu_b = ext_o(fsize);
      end
      ffha_pkg::S_PWR: begin
        we    = 1'b1;
        waddr = i_dec[IW-1:0];
        wdata = {1'b1, acc[OB-1:0], foff};
      end
      default: begin
      end
    endcase
  end

  assign idle      = (state == ffha_pkg::S_IDLE);
  assign res_valid = (state == ffha_pkg::S_DONE);
  assign res       = '{status: status, grant_addr: gaddr, grant_size: gsize};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ffha_pkg::S_IDLE;
      ret        <= ffha_pkg::S_IDLE;
      heap_ready <= 1'b0;
      count      <= '0;
      i          <= '0;
      k          <= '0;
      shift_up   <= 1'b0;
      split      <= 1'b0;
      status     <= ffha_pkg::ST_OK;
    end else begin
      state <= state_next;
      case (state)
        ffha_pkg::S_IDLE: begin
          if (start) begin
            req    <= cmd_in.req_size;
            faddr  <= cmd_in.free_addr;
            i      <= '0;
            gaddr  <= '0;
            gsize  <= '0;
            status <= (!heap_ready && (cmd_in.cmd == ffha_pkg::OP_ALLOC ||
                                       cmd_in.cmd == ffha_pkg::OP_FREE))
                      ? ffha_pkg::ST_NOINIT : ffha_pkg::ST_OK;
          end
        end
        ffha_pkg::S_INIT: begin
          count      <= CW'(1);
          heap_ready <= 1'b1;
        end
        ffha_pkg::S_PREP1: r    <= alu_y & ~ROUND_A;
        ffha_pkg::S_PREP2: rh   <= alu_y;
        ffha_pkg::S_PREP3: thr1 <= alu_y;
        ffha_pkg::S_ARD: begin
          if (!i_lt) begin
            status <= ffha_pkg::ST_OOM;
          end
        end
        ffha_pkg::S_AEV: begin
          foff  <= rd_off;
          fsize <= rd_size;
          if (!fit) begin
            i <= i_inc[CW-1:0];
          end
        end
        ffha_pkg::S_ASPL: split <= !alu_borrow && room;
        ffha_pkg::S_NOFF: noff <= alu_y[OB-1:0];
        ffha_pkg::S_NSZ: begin
          nsz      <= alu_y[OB-1:0];
          k        <= count;
          shift_up <= 1'b1;
          ret      <= ffha_pkg::S_WNEW;
        end
        ffha_pkg::S_SRD: begin
          if (!shift_more && !shift_up) begin
            count <= count - 1'b1;
          end
        end
        ffha_pkg::S_SWR:  k     <= shift_up ? k_dec : k_inc;
        ffha_pkg::S_WNEW: count <= count + 1'b1;
        ffha_pkg::S_WCUR: begin
          gaddr <= foff_ext[FW-1:0];
          gsize <= split ? r[FW-1:0] : fsize_ext[FW-1:0];
        end
        ffha_pkg::S_FRD: begin
          if (!i_lt) begin
            status <= ffha_pkg::ST_BADFREE;
          end
        end
        ffha_pkg::S_FEV: begin
          foff <= rd_off;
          acc  <= ext_o(rd_size);
          if (!hit) begin
            i <= i_inc[CW-1:0];
          end
        end
        ffha_pkg::S_MEV: begin
          if (rd_free) begin
            acc <= alu_y;
          end
        end
        ffha_pkg::S_MADD: begin
          acc      <= alu_y;
          k        <= i_inc[CW-1:0];
          shift_up <= 1'b0;
          ret      <= ffha_pkg::S_MRD;
        end
        ffha_pkg::S_PEV: begin
          if (rd_free) begin
            foff  <= rd_off;
            fsize <= rd_size;
            acc   <= alu_y;
          end
        end
        ffha_pkg::S_PADD: acc <= alu_y;
        ffha_pkg::S_PWR: begin
          k        <= i;
          shift_up <= 1'b0;
          ret      <= ffha_pkg::S_DONE;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ src/first_fit_heap_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Address-ordered block table with split on allocate and coalesce on free.
// ----------------------------------------------------------------------------
// One request is taken at a time; ready stays low until its result has been
// handed to the output register, which can still hold the previous result
// while the next request is accepted. Init writes the first table entry.
// Allocate rounds the size, scans the table for the first free entry that
// fits and, when the block is split, moves the later entries up to make room
// for the new free entry. Free scans for the entry at the given offset, merges
// it with each free successor and then with a free predecessor, moving the
// later entries down for every merge. The table sits in a RAM with one write
// port and one read port (registered read), and one adder does every size
// and offset step. The table is not cleared after reset; init writes its
// first entry, and no other entry's contents are used before it has been
// written.
module first_fit_heap_allocator_unit #(
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int OFFSET_BITS  = ffha_pkg::OFFSET_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ffha_cfg_if.sink   cfg,
  ffha_in_if.sink    request,
  ffha_out_if.source result
);

  logic [ffha_pkg::HB_W-1:0] heap_bytes;
  logic                      seq_idle, res_valid, slot_free, out_valid;
  ffha_pkg::ffha_cmd_t       cmd_in;
  ffha_pkg::ffha_res_t       res, res_q;

  assign cfg.ready     = 1'b1;
  assign request.ready = seq_idle;
  assign slot_free     = !out_valid || result.ready;

  assign cmd_in = '{cmd:       ffha_pkg::ffha_op_t'(request.cmd),
                    req_size:  request.req_size,
                    free_addr: request.free_addr};

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_bytes <= ffha_pkg::HB_RESET;
    end else if (cfg.valid) begin
      heap_bytes <= cfg.heap_bytes;
    end
  end

  ffha_seq #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .heap_bytes (heap_bytes),
    .start      (request.valid && seq_idle),
    .cmd_in     (cmd_in),
    .idle       (seq_idle),
    .res_valid  (res_valid),
    .res_take   (slot_free),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && slot_free) begin
      res_q <= res;
    end
  end

  assign result.valid      = out_valid;
  assign result.status     = res_q.status;
  assign result.grant_addr = res_q.grant_addr;
  assign result.grant_size = res_q.grant_size;

endmodule

@@ src/ffha_checker.sv @@
// ----------------------------------------------------------------------------
// Heap allocator checker
// Port-level assertions on the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_unit_macros.svh"

module ffha_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [1:0]                   res_status,
  input logic [ffha_pkg::FIELD_W-1:0] res_addr,
  input logic [ffha_pkg::FIELD_W-1:0] res_size
);

  `FFHA_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready)
  `FFHA_ASSERT(a_error_no_grant, res_valid && res_status != ffha_pkg::ST_OK |-> res_addr == '0 && res_size == '0)
  `FFHA_ASSERT(a_result_held, res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_addr) && $stable(res_size))
  `FFHA_ASSERT_ALWAYS(a_reset_clears_result, rst |=> !res_valid)

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (request.valid),
  .req_ready  (request.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_status (result.status),
  .res_addr   (result.grant_addr),
  .res_size   (result.grant_size)
);
